@@ hw/rtl/btsd_pkg.sv @@
// Shared types and constants for the binary token string decoder.
// Holds the result kind codes, the result record and the extended-page size.
// No dependencies.
package btsd_pkg;

	// Number of valid entries over all extended token pages
	localparam int EXT_ENTRIES = 1024;
	localparam int EXT_IDX_W   = 11;

	// Result payload widths
	localparam int VALUE_W = 16;
	localparam int KIND_W  = 4;
	localparam int OUSER_W = KIND_W + 1;

	typedef enum logic [KIND_W-1:0] {
		KIND_DICT      = 4'd0,
		KIND_EXT       = 4'd1,
		KIND_EXT_RANGE = 4'd2,
		KIND_RAW_BYTE  = 4'd3,
		KIND_DIGIT     = 4'd4,
		KIND_EMPTY     = 4'd5,
		KIND_PAIR      = 4'd6,
		KIND_LIST_SIZE = 4'd7,
		KIND_LIST_ERR  = 4'd8
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [VALUE_W-1:0] value;
		logic               token_end;
		logic               last;
	} res_t;

endpackage

@@ hw/rtl/binary_token_string_decoder.sv @@
// Binary token string decoder: byte-wide token parser with a two-slot result stage.
// Depends on btsd_pkg for result kinds, the result record and the page size.
//
// A byte's first result passes the input register, then the result register, and is
// presented once the result stage has room. Throughput: one byte per cycle while
// the result stage has room; a byte that yields two digit characters holds the result
// stage for two output transactions. Bytes that only advance the parser yield nothing.
// Reset (arst_n low, asynchronous) clears parser state and all valid flags.
module binary_token_string_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] data_byte
	input  logic                        s_tuser,  // [0] list_header
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [btsd_pkg::VALUE_W-1:0] m_tdata, // [15:0] value
	output logic [btsd_pkg::OUSER_W-1:0] m_tuser, // [3:0] kind, [4] last
	output logic                        m_tlast   // token_end
);
	import btsd_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_EXT,
		PH_LEN20,
		PH_LEN31,
		PH_RAW,
		PH_NIBLEN,
		PH_NIB,
		PH_LIST
	} phase_t;

	localparam logic [EXT_IDX_W-1:0] EXT_LIMIT = EXT_IDX_W'(EXT_ENTRIES);

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       lh_s1;

	// Result stage: slot a is presented, slot b holds the second digit
	res_t res_a_s2, res_b_s2;
	logic res_a_valid_s2, res_b_valid_s2;

	// Parser state
	phase_t      phase_q, phase_nx;
	logic [30:0] remaining_q, remaining_nx;
	logic [30:0] accum_q, accum_nx;
	logic [1:0]  hbl_q, hbl_nx;
	logic [1:0]  page_q, page_nx;
	logic        hex_q, hex_nx;
	logic        odd_q, odd_nx;

	logic        pop, load_ok, advance;
	res_t        r0, r1;
	logic [1:0]  n_res;
	logic [30:0] rem_dec, accum_sh, len;
	logic [1:0]  hbl_dec;
	logic [9:0]  ext_idx;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic hex);
		logic [7:0] base;
		base = hex ? 8'h41 : 8'h2d;
		if (d < 4'd10) begin
			digit_char = 8'h30 + {4'd0, d};
		end else begin
			digit_char = base + {4'd0, d} - 8'd10;
		end
	endfunction

	// Handshake between stages
	assign pop      = res_a_valid_s2 && m_tready;
	assign load_ok  = !res_b_valid_s2 && (!res_a_valid_s2 || pop);
	assign advance  = valid_s1 && load_ok;
	assign s_tready = !valid_s1 || load_ok;

	assign m_tvalid = res_a_valid_s2;
	assign m_tdata  = res_a_s2.value;
	assign m_tuser  = {res_a_s2.last, res_a_s2.kind};
	assign m_tlast  = res_a_s2.token_end;

	assign rem_dec  = remaining_q - 31'd1;
	assign accum_sh = {accum_q[22:0], byte_s1};
	assign hbl_dec  = hbl_q - 2'd1;
	assign ext_idx  = {page_q, byte_s1};
	assign len      = (phase_q == PH_LEN20) ? {11'd0, accum_sh[19:0]} : accum_sh;

	// Token parser: next state and up to two results for the byte in s1
	always_comb begin
		phase_nx     = phase_q;
		remaining_nx = remaining_q;
		accum_nx     = accum_q;
		hbl_nx       = hbl_q;
		page_nx      = page_q;
		hex_nx       = hex_q;
		odd_nx       = odd_q;
		r0           = '0;
		r1           = '0;
		n_res        = 2'd0;
		case (phase_q)
			PH_IDLE: begin
				if (lh_s1) begin
					if (byte_s1 == 8'h00) begin
						r0 = '{KIND_LIST_SIZE, '0, 1'b1, 1'b0};
						n_res = 2'd1;
					end else if (byte_s1 == 8'hf8) begin
						hbl_nx = 2'd1; accum_nx = '0; phase_nx = PH_LIST;
					end else if (byte_s1 == 8'hf9) begin
						hbl_nx = 2'd2; accum_nx = '0; phase_nx = PH_LIST;
					end else begin
						r0 = '{KIND_LIST_ERR, {8'd0, byte_s1}, 1'b1, 1'b0};
						n_res = 2'd1;
					end
				end else if (byte_s1 < 8'd236) begin
					r0 = '{KIND_DICT, {8'd0, byte_s1}, 1'b1, 1'b0};
					n_res = 2'd1;
				end else if (byte_s1 <= 8'd239) begin
					page_nx = byte_s1[1:0];
					phase_nx = PH_EXT;
				end else if (byte_s1 == 8'd250) begin
					r0 = '{KIND_PAIR, '0, 1'b0, 1'b0};
					n_res = 2'd1;
				end else if (byte_s1 == 8'd252) begin
					hbl_nx = 2'd1; accum_nx = '0; phase_nx = PH_LEN31;
				end else if (byte_s1 == 8'd253) begin
					hbl_nx = 2'd3; accum_nx = '0; phase_nx = PH_LEN20;
				end else if (byte_s1 == 8'd254) begin
					// zero in the byte counter stands for four length bytes
					hbl_nx = 2'd0; accum_nx = '0; phase_nx = PH_LEN31;
				end else if (byte_s1 == 8'd251 || byte_s1 == 8'd255) begin
					hex_nx = (byte_s1 == 8'd251);
					phase_nx = PH_NIBLEN;
				end else begin
					r0 = '{KIND_EMPTY, '0, 1'b1, 1'b0};
					n_res = 2'd1;
				end
			end
			PH_EXT: begin
				r0.kind = ({1'b0, ext_idx} < EXT_LIMIT) ? KIND_EXT : KIND_EXT_RANGE;
				r0.value = {6'd0, ext_idx};
				r0.token_end = 1'b1;
				n_res = 2'd1;
				phase_nx = PH_IDLE;
			end
			PH_LEN20, PH_LEN31: begin
				accum_nx = accum_sh;
				hbl_nx = hbl_dec;
				if (hbl_dec == 2'd0) begin
					if (len == 31'd0) begin
						r0 = '{KIND_EMPTY, '0, 1'b1, 1'b0};
						n_res = 2'd1;
						phase_nx = PH_IDLE;
					end else begin
						remaining_nx = len;
						phase_nx = PH_RAW;
					end
				end
			end
			PH_RAW: begin
				remaining_nx = rem_dec;
				r0 = '{KIND_RAW_BYTE, {8'd0, byte_s1}, (rem_dec == 31'd0), 1'b0};
				n_res = 2'd1;
				if (rem_dec == 31'd0) begin
					phase_nx = PH_IDLE;
				end
			end
			PH_NIBLEN: begin
				remaining_nx = {24'd0, byte_s1[6:0]};
				odd_nx = byte_s1[7];
				if (byte_s1[6:0] == 7'd0) begin
					r0 = '{KIND_EMPTY, '0, 1'b1, 1'b0};
					n_res = 2'd1;
					phase_nx = PH_IDLE;
				end else begin
					phase_nx = PH_NIB;
				end
			end
			PH_NIB: begin
				remaining_nx = rem_dec;
				r0.kind = KIND_DIGIT;
				r0.value = {8'd0, digit_char(byte_s1[7:4], hex_q)};
				// pad nibble of an odd digit count is dropped
				if (rem_dec == 31'd0 && odd_q) begin
					r0.token_end = 1'b1;
					n_res = 2'd1;
				end else begin
					r1.kind = KIND_DIGIT;
					r1.value = {8'd0, digit_char(byte_s1[3:0], hex_q)};
					r1.token_end = (rem_dec == 31'd0);
					n_res = 2'd2;
				end
				if (rem_dec == 31'd0) begin
					phase_nx = PH_IDLE;
				end
			end
			PH_LIST: begin
				accum_nx = {15'd0, accum_q[7:0], byte_s1};
				hbl_nx = hbl_dec;
				if (hbl_dec == 2'd0) begin
					r0 = '{KIND_LIST_SIZE, {accum_q[7:0], byte_s1}, 1'b1, 1'b0};
					n_res = 2'd1;
					phase_nx = PH_IDLE;
				end
			end
			default: begin
				phase_nx = PH_IDLE;
			end
		endcase
		// mark the final result of this byte
		if (n_res == 2'd1) begin
			r0.last = 1'b1;
		end
		if (n_res == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	// Control: valid flags and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			res_a_valid_s2 <= 1'b0;
			res_b_valid_s2 <= 1'b0;
			phase_q        <= PH_IDLE;
			remaining_q    <= '0;
			accum_q        <= '0;
			hbl_q          <= '0;
			page_q         <= '0;
			hex_q          <= 1'b0;
			odd_q          <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			// a new byte only loads when slot b is empty
			if (advance && n_res != 2'd0) begin
				res_a_valid_s2 <= 1'b1;
			end else if (pop) begin
				res_a_valid_s2 <= res_b_valid_s2;
			end
			if (advance && n_res == 2'd2) begin
				res_b_valid_s2 <= 1'b1;
			end else if (pop) begin
				res_b_valid_s2 <= 1'b0;
			end
			if (advance) begin
				phase_q     <= phase_nx;
				remaining_q <= remaining_nx;
				accum_q     <= accum_nx;
				hbl_q       <= hbl_nx;
				page_q      <= page_nx;
				hex_q       <= hex_nx;
				odd_q       <= odd_nx;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			lh_s1   <= s_tuser;
		end
		if (advance && n_res != 2'd0) begin
			res_a_s2 <= r0;
		end else if (pop && res_b_valid_s2) begin
			res_a_s2 <= res_b_s2;
		end
		if (advance && n_res == 2'd2) begin
			res_b_s2 <= r1;
		end
	end

	// Checks
	a_b_needs_a: assert property (@(posedge clk) disable iff (!arst_n)
		res_b_valid_s2 |-> res_a_valid_s2)
		else $error("second result slot filled while first is empty");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !res_b_valid_s2)
		else $error("byte processed while result stage is full");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_b_valid_s2 |-> (!res_a_s2.last && res_b_s2.last))
		else $error("digit pair last flag misplaced");

	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RAW || phase_q == PH_NIB) |-> (remaining_q != 31'd0))
		else $error("string phase with zero bytes remaining");

	a_list_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LIST) |-> (hbl_q != 2'd0))
		else $error("list header phase with no bytes left");

endmodule
